// ----- rtl/mi_pkg.sv -----
`default_nettype none
// ============================================================================
// mi_pkg - shared constants and types for the modular inverse block
// Word width, stream widths, status codes and divider interface types.
// ============================================================================
package mi_pkg;

    // operand width
    localparam int WORD_BITS = 32;

    // coefficient magnitude width, one guard bit
    localparam int COEF_BITS = WORD_BITS + 1;

    // divider bit counter, holds WORD_BITS itself
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_BITS  = ((2 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

    // result status
    typedef enum logic [0:0] {
        STATUS_OK          = 1'b0,
        STATUS_NOT_COPRIME = 1'b1
    } t_status;

    // divider start request and operands
    typedef struct packed {
        logic                   start;
        logic [WORD_BITS-1:0]   dividend;
        logic [WORD_BITS-1:0]   divisor;
        logic [COEF_BITS-1:0]   mult;
    } t_div_req;

    // divider results
    typedef struct packed {
        logic                   done;
        logic [WORD_BITS-1:0]   rem;
        logic [COEF_BITS-1:0]   prod;
    } t_div_rsp;

endpackage : mi_pkg
`default_nettype wire

// ----- rtl/mi_divider.sv -----
`default_nettype none
// ============================================================================
// mi_divider - shared radix-2 divide and multiply unit
// Restoring division, one quotient bit per cycle. Quotient bits come out
// MSB first and are folded into q * mult by Horner accumulation, so the
// quotient itself is never stored.
// ============================================================================
module mi_divider (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mi_pkg::t_div_req i_req,
    output mi_pkg::t_div_rsp      o_rsp
);
    import mi_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_quo;
    logic [WORD_BITS-1:0] r_div;
    logic [COEF_BITS-1:0] r_mult;
    logic [COEF_BITS-1:0] r_acc;

    logic [WORD_BITS:0]   n_shift;
    logic                 n_ge;
    logic [WORD_BITS:0]   n_diff;
    logic [COEF_BITS-1:0] n_acc;

    // one restoring step plus the product accumulate
    always_comb begin
        n_shift = {r_rem, r_quo[WORD_BITS-1]};
        n_ge    = (n_shift >= {1'b0, r_div});
        n_diff  = n_shift - {1'b0, r_div};
        n_acc   = {r_acc[COEF_BITS-2:0], 1'b0} + (n_ge ? r_mult : '0);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses the cycle after the last step
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_BITS'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_mult <= i_req.mult;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[WORD_BITS-1:0] : n_shift[WORD_BITS-1:0];
            r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.prod = r_acc;

endmodule : mi_divider
`default_nettype wire

// ----- rtl/modular_inverse.sv -----
`default_nettype none
// ============================================================================
// modular_inverse - extended Euclidean modular inverse
// Each Euclid step runs one pass of the shared bit-serial divider, which sets
// the step time; up to about 46 steps for 32-bit operands. One request at a
// time; a new request is taken while the previous result waits on the output.
// Reset: synchronous active-low i_rst_n clears sequencer and output valid.
// ============================================================================
module modular_inverse (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: value [WORD_BITS-1:0], modulus [2*WORD_BITS-1:WORD_BITS]
    input  wire logic [mi_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata: inverse [WORD_BITS-1:0], zero padded
    output logic [mi_pkg::OUT_TDATA_BITS-1:0]         m_axis_tdata,
    // tuser: status [0]
    output logic [0:0]                                m_axis_tuser
);
    import mi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state               r_state;
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_nr;
    logic [COEF_BITS-1:0] r_tm;
    logic [COEF_BITS-1:0] r_ntm;
    logic                 r_odd;
    logic                 r_any;
    logic                 r_start;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_inv;
    t_status              r_out_status;

    t_div_req             w_req;
    t_div_rsp             w_rsp;
    logic                 w_in_req;
    logic                 w_out_free;
    logic                 w_neg;
    logic [COEF_BITS-1:0] w_diff;
    logic [COEF_BITS-1:0] w_next_tm;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_req      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // divider request: r / nr, product q * ntm
    assign w_req.start    = r_start;
    assign w_req.dividend = r_r;
    assign w_req.divisor  = r_nr;
    assign w_req.mult     = r_ntm;

    mi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // coefficient update and final sign fix
    always_comb begin
        w_next_tm = r_tm + w_rsp.prod;
        w_neg     = r_any && !r_odd && (r_tm != '0);
        w_diff    = {1'b0, r_mod} - r_tm;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // kick the divider once a nonzero divisor is seen
            r_start <= (r_state == ST_CHECK) && (r_nr != '0);
            // output valid: set on result load, cleared on accept
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_req) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_nr == '0) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_rsp.done) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Euclid operands and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_nr  <= s_axis_tdata[WORD_BITS-1:0];
            r_mod <= s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
            r_r   <= s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
            r_tm  <= '0;
            r_ntm <= COEF_BITS'(1);
            r_odd <= 1'b0;
            r_any <= 1'b0;
        end else if (r_state == ST_DIV && w_rsp.done) begin
            r_r   <= r_nr;
            r_nr  <= w_rsp.rem;
            r_tm  <= r_ntm;
            r_ntm <= w_next_tm;
            r_odd <= !r_odd;
            r_any <= 1'b1;
        end
        if (r_state == ST_FINISH && w_out_free) begin
            if (r_r == WORD_BITS'(1)) begin
                r_out_status <= STATUS_OK;
                r_out_inv    <= w_neg ? w_diff[WORD_BITS-1:0] : r_tm[WORD_BITS-1:0];
            end else begin
                r_out_status <= STATUS_NOT_COPRIME;
                r_out_inv    <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'(r_out_inv);
    assign m_axis_tuser  = r_out_status;

endmodule : modular_inverse
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ============================================================================
// tb_top - stream testbench for the modular inverse block
// Feeds value/modulus requests (directed corner cases, then random mixes)
// through a queue-fed driver. A monitor predicts each inverse and status with
// its own extended Euclid model and checks results in order. Both sides idle
// at random in the first two of three pacing phases.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mi_pkg::*;

    localparam int WB         = WORD_BITS;
    // no request or result moving for this long means the block hung
    localparam int HANG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 200;

    typedef struct {
        logic [WB-1:0] value;
        logic [WB-1:0] modulus;
    } inv_req_t;

    typedef struct {
        logic [WB-1:0] value;
        logic [WB-1:0] modulus;
        logic [WB-1:0] inverse;
        t_status       status;
    } inv_result_t;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // tdata: value [WB-1:0], modulus [2*WB-1:WB]
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // tdata: inverse [WB-1:0]
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    // tuser: status [0]
    logic [0:0]                m_axis_tuser;

    inv_req_t    req_q[$];
    inv_result_t inv_expect_q[$];

    int unsigned rst_cycles   = 0;
    int unsigned total_reqs   = 0;
    int unsigned sent_reqs    = 0;
    int unsigned checked      = 0;
    int unsigned not_coprime  = 0;
    int unsigned err_cnt      = 0;
    int unsigned quiet_cycles = 0;

    wire in_acc  = s_axis_tvalid && s_axis_tready;
    wire out_acc = m_axis_tvalid && m_axis_tready;

    modular_inverse u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // reset held low at the start of the run, then released
    always @(posedge i_clk) begin
        if (rst_cycles < 10) begin
            rst_cycles <= rst_cycles + 1;
            i_rst_n    <= (rst_cycles == 9);
        end
    end

    // extended Euclid on (modulus, value); coefficient kept as magnitude,
    // sign alternates with the step count
    function automatic inv_result_t euclid_inverse(logic [WB-1:0] value,
                                                   logic [WB-1:0] modulus);
        logic [2*WB-1:0] r;
        logic [2*WB-1:0] nr;
        logic [2*WB-1:0] q;
        logic [2*WB-1:0] rem;
        logic [2*WB-1:0] tm;
        logic [2*WB-1:0] ntm;
        logic [2*WB-1:0] nxt;
        int unsigned     steps;
        logic            neg;
        inv_result_t     res;
        r     = modulus;
        nr    = value;
        tm    = 0;
        ntm   = 1;
        steps = 0;
        while (nr != 0) begin
            q     = r / nr;
            rem   = r % nr;
            nxt   = tm + q * ntm;
            tm    = ntm;
            ntm   = nxt;
            r     = nr;
            nr    = rem;
            steps = steps + 1;
        end
        res.value   = value;
        res.modulus = modulus;
        if (r != 1) begin
            res.inverse = '0;
            res.status  = STATUS_NOT_COPRIME;
        end else begin
            neg         = (steps != 0) && !steps[0] && (tm != 0);
            res.inverse = neg ? WB'(modulus - tm) : WB'(tm);
            res.status  = STATUS_OK;
        end
        return res;
    endfunction

    function automatic int unsigned send_idle_pct();
        if (sent_reqs < total_reqs / 3)
            return 28;
        else if (sent_reqs < 2 * total_reqs / 3)
            return 47;
        return 0;
    endfunction

    function automatic int unsigned recv_idle_pct();
        if (sent_reqs < total_reqs / 3)
            return 47;
        else if (sent_reqs < 2 * total_reqs / 3)
            return 28;
        return 0;
    endfunction

    task automatic add_req(logic [WB-1:0] value, logic [WB-1:0] modulus);
        inv_req_t req;
        req.value   = value;
        req.modulus = modulus;
        req_q.insert(req_q.size(), req);
    endtask

    // request driver
    always @(posedge i_clk) begin
        inv_req_t req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
            if (!s_axis_tvalid || in_acc) begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    req = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req.modulus, req.value};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on request, check on result
    always @(posedge i_clk) begin
        inv_result_t want;
        if (i_rst_n) begin
            if (in_acc) begin
                inv_expect_q.insert(inv_expect_q.size(),
                                    euclid_inverse(s_axis_tdata[WB-1:0],
                                                   s_axis_tdata[2*WB-1:WB]));
                sent_reqs <= sent_reqs + 1;
            end
            if (out_acc) begin
                if (inv_expect_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected result: inv %h status %0d",
                                 m_axis_tdata[WB-1:0], m_axis_tuser[0]);
                    err_cnt <= err_cnt + 1;
                end else begin
                    want = inv_expect_q.pop_front();
                    checked <= checked + 1;
                    if (want.status == STATUS_NOT_COPRIME)
                        not_coprime <= not_coprime + 1;
                    if (m_axis_tdata[WB-1:0] !== want.inverse
                            || m_axis_tuser[0] !== want.status) begin
                        if (err_cnt < 10)
                            $display({"mismatch: value %h modulus %h: expected inv %h ",
                                      "status %0d, got inv %h status %0d"},
                                     want.value, want.modulus, want.inverse, want.status,
                                     m_axis_tdata[WB-1:0], m_axis_tuser[0]);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
    end

    // hang watchdog: counts cycles with work pending but nothing moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc || out_acc
                    || (req_q.size() == 0 && !s_axis_tvalid && inv_expect_q.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", HANG_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned     kind;
        int unsigned     k;
        logic [WB-1:0]   fa;
        logic [WB-1:0]   fb;
        logic [WB-1:0]   ft;
        logic [WB-1:0]   v;
        logic [WB-1:0]   m;

        // directed corners: zero and unit moduli, both zero, value above
        // modulus, shared factors, full-range and 2^31 moduli, worst-case chain
        add_req(32'd0, 32'd0);
        add_req(32'd1, 32'd0);
        add_req(32'd9, 32'd0);
        add_req(32'd0, 32'd1);
        add_req(32'd1, 32'd1);
        add_req(32'hFFFF_FFFF, 32'd1);
        add_req(32'd0, 32'd12);
        add_req(32'd3, 32'd7);
        add_req(32'd10, 32'd7);
        add_req(32'd6, 32'd9);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_req(32'd1, 32'hFFFF_FFFF);
        add_req(32'd2, 32'hFFFF_FFFF);
        add_req(32'd65537, 32'hFFFF_FFFF);
        add_req(32'h7FFF_FFFF, 32'h8000_0000);
        add_req(32'd3, 32'h8000_0000);
        add_req(32'h8000_0000, 32'd3);
        add_req(32'd1836311903, 32'd2971215073);
        add_req(32'd2971215073, 32'd1836311903);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFB);
        add_req(32'hAAAA_AAAA, 32'h5555_5555);
        add_req(32'd65537, 32'hFFFF_FFFA);

        // random mix
        repeat (346) begin
            kind = $urandom_range(0, 9);
            v    = $urandom();
            m    = $urandom();
            case (kind)
                3: begin
                    m = $urandom_range(0, 64);
                    v = $urandom_range(0, 200);
                end
                4: begin
                    m[WB-1] = 1'b1;
                end
                5: begin
                    m    = '0;
                    m[$urandom_range(0, WB-1)] = 1'b1;
                    v[0] = 1'b1;
                end
                6: begin
                    m = $urandom_range(1, 65535);
                end
                7: begin
                    // consecutive Fibonacci terms give the longest chains
                    k  = $urandom_range(20, 45);
                    fa = 1;
                    fb = 1;
                    repeat (k) begin
                        ft = fa + fb;
                        fa = fb;
                        fb = ft;
                    end
                    if ($urandom_range(0, 1) != 0) begin
                        v = fa;
                        m = fb;
                    end else begin
                        v = fb;
                        m = fa;
                    end
                end
                8: begin
                    m[0] = 1'b1;
                end
                9: begin
                    case ($urandom_range(0, 3))
                        0: v = '0;
                        1: m = '0;
                        2: v = 1;
                        default: m = 1;
                    endcase
                end
                default: ;
            endcase
            add_req(v, m);
        end
        total_reqs = req_q.size();

        wait (i_rst_n);
        while (req_q.size() != 0 || s_axis_tvalid || inv_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb_top: %0d requests sent, %0d results checked (%0d not coprime)",
                 sent_reqs, checked, not_coprime);
        $display("tb_top: directed corners plus random mix over three pacing phases");
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: %0d mismatches", err_cnt);
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule : tb_top

// ----- files.f -----
rtl/mi_pkg.sv
rtl/mi_divider.sv
rtl/modular_inverse.sv
tb/sv/tb_top.sv
